// ===== hw/rtl/qte_pkg.sv =====
// shared types and constants for the quaternion to euler angle pipeline
`default_nettype none

package qte_pkg;

	// field widths
	localparam int ANG_W   = 16;
	localparam int Q_W     = 16;
	localparam int TERM_W  = 34;
	localparam int CW      = 36;
	localparam int ACC_W   = 32;
	localparam int ITERS   = 30;
	localparam int SQ_W    = 61;
	localparam int ROOT_W  = 31;
	localparam int SQ_STEPS = 31;
	localparam int SP_W    = 31;

	localparam int CORDIC_LAT = ITERS + 2;
	localparam int PITCH_MAX  = 16384;

	typedef logic signed [Q_W-1:0]   q_t;
	typedef logic signed [ANG_W-1:0] ang_t;
	typedef logic signed [CW-1:0]    cw_t;
	typedef logic [ACC_W-1:0]        acc_t;
	typedef logic [SQ_W-1:0]         sq_t;
	typedef logic [ROOT_W-1:0]       root_t;

	// atan(2^-i) in units of 2^-32 turn
	localparam acc_t ATAN_TAB [0:ITERS-1] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
	};

endpackage

`default_nettype wire

// ===== hw/rtl/qte_isqrt.sv =====
// pipelined integer square root, one result bit per stage
`default_nettype none

module qte_isqrt (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire qte_pkg::sq_t  n_in,
	output qte_pkg::root_t     root
);
	import qte_pkg::*;

	localparam int RW = SQ_W + 1;

	logic [RW-1:0] rem_s [0:SQ_STEPS-1];
	logic [RW-1:0] res_s [0:SQ_STEPS-1];

	// one digit step per stage, trial bit walks down by two places
	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
		localparam logic [RW-1:0] BIT = RW'(1) << (2 * (SQ_STEPS - 1 - k));
		logic [RW-1:0] rem_in;
		logic [RW-1:0] res_in;
		logic [RW-1:0] trial;
		if (k == 0) begin : g_first
			assign rem_in = {1'b0, n_in};
			assign res_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign res_in = res_s[k-1];
		end
		assign trial = res_in + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_in >= trial) begin
					rem_s[k] <= rem_in - trial;
					res_s[k] <= (res_in >> 1) + BIT;
				end else begin
					rem_s[k] <= rem_in;
					res_s[k] <= res_in >> 1;
				end
			end
		end
	end

	assign root = res_s[SQ_STEPS-1][ROOT_W-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/qte_cordic.sv =====
// pipelined cordic vectoring unit giving a 16-bit binary angle of atan2
`default_nettype none

module qte_cordic (
	input  wire logic         clk,
	input  wire logic         en,
	input  wire qte_pkg::cw_t x_in,
	input  wire qte_pkg::cw_t y_in,
	output qte_pkg::ang_t     ang
);
	import qte_pkg::*;

	cw_t  x_s    [0:ITERS];
	cw_t  y_s    [0:ITERS];
	acc_t acc_s  [0:ITERS];
	logic zero_s [0:ITERS];
	acc_t rnd;
	ang_t ang_q;

	// fold the left half plane over, starting the angle at pi
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (x_in == '0) && (y_in == '0);
			if (x_in[CW-1]) begin
				x_s[0]   <= -x_in;
				y_s[0]   <= -y_in;
				acc_s[0] <= acc_t'(1) << (ACC_W - 1);
			end else begin
				x_s[0]   <= x_in;
				y_s[0]   <= y_in;
				acc_s[0] <= '0;
			end
		end
	end

	// micro-rotations toward the x axis
	for (genvar i = 0; i < ITERS; i++) begin : g_iter
		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[i+1] <= zero_s[i];
				if (!y_s[i][CW-1]) begin
					x_s[i+1]   <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1]   <= y_s[i] - (x_s[i] >>> i);
					acc_s[i+1] <= acc_s[i] + ATAN_TAB[i];
				end else begin
					x_s[i+1]   <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1]   <= y_s[i] + (x_s[i] >>> i);
					acc_s[i+1] <= acc_s[i] - ATAN_TAB[i];
				end
			end
		end
	end

	// round to 16 bits
	assign rnd = acc_s[ITERS] + acc_t'(32'h8000);

	always_ff @(posedge clk) begin
		if (en) begin
			ang_q <= zero_s[ITERS] ? '0 : ang_t'(rnd[ACC_W-1:ACC_W-ANG_W]);
		end
	end

	assign ang = ang_q;

endmodule

`default_nettype wire

// ===== hw/rtl/quaternion_to_euler_angles_top.sv =====
// quaternion to roll, pitch and yaw pipeline, top level
//
// channel  direction  handshake              word
// input    in         in_valid / in_ready    quat_w, quat_x, quat_y, quat_z
// output   out        out_valid / out_ready  roll_angle, pitch_angle, yaw_angle, pitch_clamped
//
// one word accepted per cycle while the output word is not held
// latency is set by the 31-stage square root followed by the 32-stage cordic on pitch
// roll and yaw run their own cordic units and wait in a delay line alongside
// a stall at the output holds every stage at once, nothing is dropped or repeated
// reset clears only the valid bits
`default_nettype none

module quaternion_to_euler_angles_top (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire qte_pkg::q_t   quat_w,
	input  wire qte_pkg::q_t   quat_x,
	input  wire qte_pkg::q_t   quat_y,
	input  wire qte_pkg::q_t   quat_z,
	output logic               out_valid,
	input  wire logic          out_ready,
	output qte_pkg::ang_t      roll_angle,
	output qte_pkg::ang_t      pitch_angle,
	output qte_pkg::ang_t      yaw_angle,
	output logic               pitch_clamped
);
	import qte_pkg::*;

	localparam int PITCH_LAT = 2 + SQ_STEPS + CORDIC_LAT + 1;
	localparam int LAT       = 2 + PITCH_LAT;
	localparam int RY_DLY    = PITCH_LAT - CORDIC_LAT;
	localparam int FLAG_DLY  = PITCH_LAT - 2;
	localparam int SP_DLY    = 1 + SQ_STEPS;

	typedef logic signed [2*Q_W-1:0]  prod_t;
	typedef logic signed [TERM_W-1:0] term_t;
	typedef logic signed [SP_W-1:0]   sp_t;

	logic adv;
	logic v_q [0:LAT-1];

	prod_t wx_s1, yz_s1, wy_s1, zx_s1, wz_s1, xy_s1, xx_s1, yy_s1, zz_s1;
	term_t sr_s2, cr_s2, sp_s2, sy_s2, cy_s2;
	sq_t   sq_s3, n_s4;
	logic  clamp_s3, pos_s3;
	sp_t   sp_s3;
	logic signed [2*SP_W-1:0] sq_full;

	sp_t   sp_d    [0:SP_DLY-1];
	logic  clamp_d [0:FLAG_DLY-1];
	logic  pos_d   [0:FLAG_DLY-1];
	ang_t  roll_d  [0:RY_DLY-1];
	ang_t  yaw_d   [0:RY_DLY-1];

	root_t root;
	ang_t  roll_raw, yaw_raw, pitch_raw;
	ang_t  pitch_q;
	logic  clamp_q;

	// whole pipeline moves together unless the output word is held
	assign adv      = !v_q[LAT-1] || out_ready;
	assign in_ready = adv;

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LAT; k++) v_q[k] <= 1'b0;
		end else if (adv) begin
			v_q[0] <= in_valid;
			for (int k = 1; k < LAT; k++) v_q[k] <= v_q[k-1];
		end
	end

	// component products
	always_ff @(posedge clk) begin
		if (adv) begin
			wx_s1 <= quat_w * quat_x;
			yz_s1 <= quat_y * quat_z;
			wy_s1 <= quat_w * quat_y;
			zx_s1 <= quat_z * quat_x;
			wz_s1 <= quat_w * quat_z;
			xy_s1 <= quat_x * quat_y;
			xx_s1 <= quat_x * quat_x;
			yy_s1 <= quat_y * quat_y;
			zz_s1 <= quat_z * quat_z;
		end
	end

	// sine and cosine terms in q30
	always_ff @(posedge clk) begin
		if (adv) begin
			sr_s2 <= (term_t'(wx_s1) + term_t'(yz_s1)) <<< 1;
			sp_s2 <= (term_t'(wy_s1) - term_t'(zx_s1)) <<< 1;
			sy_s2 <= (term_t'(wz_s1) + term_t'(xy_s1)) <<< 1;
			cr_s2 <= (term_t'(1) <<< 30) - ((term_t'(xx_s1) + term_t'(yy_s1)) <<< 1);
			cy_s2 <= (term_t'(1) <<< 30) - ((term_t'(yy_s1) + term_t'(zz_s1)) <<< 1);
		end
	end

	// roll and yaw cordic units
	qte_cordic u_roll (
		.clk  (clk),
		.en   (adv),
		.x_in (cw_t'(cr_s2)),
		.y_in (cw_t'(sr_s2)),
		.ang  (roll_raw)
	);

	qte_cordic u_yaw (
		.clk  (clk),
		.en   (adv),
		.x_in (cw_t'(cy_s2)),
		.y_in (cw_t'(sy_s2)),
		.ang  (yaw_raw)
	);

	// pitch: saturation check and square of the sine term
	assign sq_full = sp_t'(sp_s2[SP_W-1:0]) * sp_t'(sp_s2[SP_W-1:0]);

	always_ff @(posedge clk) begin
		if (adv) begin
			clamp_s3 <= (sp_s2 >= (term_t'(1) <<< 30)) || (sp_s2 <= -(term_t'(1) <<< 30));
			pos_s3   <= (sp_s2 > term_t'(0));
			sp_s3    <= sp_t'(sp_s2[SP_W-1:0]);
			sq_s3    <= sq_t'(sq_full[SQ_W-1:0]);
			n_s4     <= (sq_t'(1) << 60) - sq_s3;
		end
	end

	// cosine of pitch by square root of one minus sine squared
	qte_isqrt u_sqrt (
		.clk  (clk),
		.en   (adv),
		.n_in (n_s4),
		.root (root)
	);

	// side data kept in step with the pitch path
	always_ff @(posedge clk) begin
		if (adv) begin
			sp_d[0]    <= sp_s3;
			clamp_d[0] <= clamp_s3;
			pos_d[0]   <= pos_s3;
			roll_d[0]  <= roll_raw;
			yaw_d[0]   <= yaw_raw;
			for (int k = 1; k < SP_DLY; k++) sp_d[k] <= sp_d[k-1];
			for (int k = 1; k < FLAG_DLY; k++) begin
				clamp_d[k] <= clamp_d[k-1];
				pos_d[k]   <= pos_d[k-1];
			end
			for (int k = 1; k < RY_DLY; k++) begin
				roll_d[k] <= roll_d[k-1];
				yaw_d[k]  <= yaw_d[k-1];
			end
		end
	end

	qte_cordic u_pitch (
		.clk  (clk),
		.en   (adv),
		.x_in (cw_t'({1'b0, root})),
		.y_in (cw_t'(sp_d[SP_DLY-1])),
		.ang  (pitch_raw)
	);

	// limit pitch to a quarter turn, saturate when the sine term reached one
	always_ff @(posedge clk) begin
		if (adv) begin
			clamp_q <= clamp_d[FLAG_DLY-1];
			if (clamp_d[FLAG_DLY-1]) begin
				pitch_q <= pos_d[FLAG_DLY-1] ? ang_t'(PITCH_MAX) : -ang_t'(PITCH_MAX);
			end else if (pitch_raw > ang_t'(PITCH_MAX)) begin
				pitch_q <= ang_t'(PITCH_MAX);
			end else if (pitch_raw < -ang_t'(PITCH_MAX)) begin
				pitch_q <= -ang_t'(PITCH_MAX);
			end else begin
				pitch_q <= pitch_raw;
			end
		end
	end

	assign out_valid     = v_q[LAT-1];
	assign roll_angle    = roll_d[RY_DLY-1];
	assign yaw_angle     = yaw_d[RY_DLY-1];
	assign pitch_angle   = pitch_q;
	assign pitch_clamped = clamp_q;

	// checks
	a_stall_only_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no word waiting at the output");

	a_clamp_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pitch_clamped |->
		(pitch_angle == ang_t'(PITCH_MAX)) || (pitch_angle == -ang_t'(PITCH_MAX)))
		else $error("saturated pitch is not a quarter turn");

	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |->
		(pitch_angle <= ang_t'(PITCH_MAX)) && (pitch_angle >= -ang_t'(PITCH_MAX)))
		else $error("pitch outside a quarter turn");

endmodule

`default_nettype wire

// ===== test/tb_quaternion_to_euler_angles_top.sv =====
// testbench for the quaternion to roll, pitch and yaw pipeline
`timescale 1ns / 1ps

module tb_quaternion_to_euler_angles_top;
	import qte_pkg::*;

	localparam int  N_RANDOM   = 1730;
	localparam int  CYCLE_CAP  = 600000;
	localparam int  DRAIN_WAIT = 100;
	localparam int  HOLD_LEN   = 400;
	localparam longint ONE_Q30 = 64'sd1 << 30;

	typedef struct packed {
		ang_t roll;
		ang_t pitch;
		ang_t yaw;
		logic clamped;
	} euler_t;

	typedef struct {
		q_t     w, x, y, z;
		logic   typed;
		euler_t res;
	} quat_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	q_t   quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	ang_t roll_angle, pitch_angle, yaw_angle;
	logic pitch_clamped;

	euler_t angles_due[$];
	int     n_errors = 0;
	int     n_cycles = 0;
	int     n_seen = 0;

	quaternion_to_euler_angles_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.roll_angle(roll_angle), .pitch_angle(pitch_angle),
		.yaw_angle(yaw_angle), .pitch_clamped(pitch_clamped)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// cycle budget
	always @(posedge clk) begin
		n_cycles <= n_cycles + 1;
		if (n_cycles > CYCLE_CAP) begin
			$display("FAIL quaternion_to_euler_angles_top");
			$finish;
		end
	end

	// vectoring cordic, binary angle of (sx, sy)
	function automatic ang_t cordic_angle(longint sy, longint sx);
		longint a, b, da, db;
		logic [31:0] acc, rnd;
		a = sx;
		b = sy;
		acc = '0;
		if (a == 0 && b == 0) return '0;
		if (a < 0) begin
			a = -a;
			b = -b;
			acc = 32'h8000_0000;
		end
		for (int i = 0; i < ITERS; i++) begin
			da = b >>> i;
			db = a >>> i;
			if (b >= 0) begin
				a += da;
				b -= db;
				acc += ATAN_TAB[i];
			end else begin
				a -= da;
				b += db;
				acc -= ATAN_TAB[i];
			end
		end
		rnd = acc + 32'h8000;
		return rnd[31:16];
	endfunction

	// floor square root of a 64-bit value
	function automatic longint floor_root(logic [63:0] n);
		logic [63:0] res, bit_v;
		res = '0;
		bit_v = 64'd1 << 62;
		while (bit_v > n) bit_v >>= 2;
		while (bit_v != 0) begin
			if (n >= res + bit_v) begin
				n -= res + bit_v;
				res = (res >> 1) + bit_v;
			end else begin
				res >>= 1;
			end
			bit_v >>= 2;
		end
		return longint'(res);
	endfunction

	function automatic euler_t predict_euler(q_t qw, q_t qx, q_t qy, q_t qz);
		longint w, x, y, z, sr, cr, sp, sy, cy, c;
		int p;
		euler_t e;
		w = qw; x = qx; y = qy; z = qz;
		sr = 2 * (w * x + y * z);
		cr = ONE_Q30 - 2 * (x * x + y * y);
		sp = 2 * (w * y - z * x);
		sy = 2 * (w * z + x * y);
		cy = ONE_Q30 - 2 * (y * y + z * z);
		if (sp >= ONE_Q30 || sp <= -ONE_Q30) begin
			e.clamped = 1'b1;
			e.pitch = (sp > 0) ? ang_t'(PITCH_MAX) : ang_t'(-PITCH_MAX);
		end else begin
			c = floor_root((64'd1 << 60) - 64'(sp * sp));
			p = cordic_angle(sp, c);
			if (p > PITCH_MAX) p = PITCH_MAX;
			if (p < -PITCH_MAX) p = -PITCH_MAX;
			e.clamped = 1'b0;
			e.pitch = ang_t'(p);
		end
		e.roll = cordic_angle(sr, cr);
		e.yaw = cordic_angle(sy, cy);
		return e;
	endfunction

	task automatic report(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, n_cycles);
		n_errors++;
	endtask

	// random quaternion, mostly near unit length
	function automatic quat_row_t random_quat();
		quat_row_t r;
		real a, b, c, d, norm;
		int sel;
		r.typed = 1'b0;
		r.res = '0;
		sel = $urandom_range(0, 9);
		if (sel < 3) begin
			r.w = q_t'($urandom); r.x = q_t'($urandom);
			r.y = q_t'($urandom); r.z = q_t'($urandom);
		end else if (sel < 5) begin
			// around the pitch saturation edge
			r.w = q_t'(23170 + $signed($urandom_range(0, 8)) - 4);
			r.y = q_t'(23170 + $signed($urandom_range(0, 8)) - 4);
			if ($urandom_range(0, 1)) r.y = -r.y;
			r.x = q_t'($signed($urandom_range(0, 6)) - 3);
			r.z = q_t'($signed($urandom_range(0, 6)) - 3);
		end else begin
			a = real'($urandom_range(0, 65535)) - 32768.0;
			b = real'($urandom_range(0, 65535)) - 32768.0;
			c = real'($urandom_range(0, 65535)) - 32768.0;
			d = real'($urandom_range(0, 65535)) - 32768.0;
			norm = $sqrt(a * a + b * b + c * c + d * d);
			if (norm < 1.0) norm = 1.0;
			r.w = q_t'($rtoi(a * 32767.0 / norm));
			r.x = q_t'($rtoi(b * 32767.0 / norm));
			r.y = q_t'($rtoi(c * 32767.0 / norm));
			r.z = q_t'($rtoi(d * 32767.0 / norm));
		end
		return r;
	endfunction

	// sender: directed table, then random words
	initial begin
		quat_row_t rows[$];
		quat_row_t r;
		int gap, burst;
		rows = '{
			'{16'sd32767, 16'sd0, 16'sd0, 16'sd0, 1'b1, '{16'sd0, 16'sd0, 16'sd0, 1'b0}},
			'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, '{16'sd0, 16'sd0, 16'sd0, 1'b0}},
			'{16'sd0, 16'sd32767, 16'sd0, 16'sd0, 1'b1, '{-16'sd32768, 16'sd0, 16'sd0, 1'b0}},
			'{-16'sd32768, 16'sd0, 16'sd32767, 16'sd0, 1'b1,
				'{-16'sd32768, -16'sd16384, -16'sd32768, 1'b1}},
			'{16'sd23171, 16'sd0, 16'sd23171, 16'sd0, 1'b0, '0},
			'{16'sd23170, 16'sd0, 16'sd23170, 16'sd0, 1'b0, '0},
			'{16'sd23170, 16'sd0, -16'sd23170, 16'sd0, 1'b0, '0},
			'{16'sd0, 16'sd0, 16'sd0, 16'sd32767, 1'b0, '0},
			'{16'sd0, 16'sd0, 16'sd32767, 16'sd0, 1'b0, '0},
			'{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 1'b0, '0},
			'{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 1'b0, '0},
			'{16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 1'b0, '0},
			'{16'sd23170, 16'sd23170, 16'sd0, 16'sd0, 1'b0, '0},
			'{16'sd23170, 16'sd0, 16'sd0, 16'sd23170, 1'b0, '0},
			'{16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384, 1'b0, '0},
			'{16'sd16384, -16'sd16384, 16'sd16384, -16'sd16384, 1'b0, '0},
			'{16'sd0, 16'sd23170, 16'sd0, 16'sd23170, 1'b0, '0},
			'{16'sd1, -16'sd1, 16'sd1, -16'sd1, 1'b0, '0},
			'{-16'sd32768, 16'sd0, 16'sd0, 16'sd0, 1'b0, '0}
		};
		for (int i = 0; i < N_RANDOM; i++) rows.push_back(random_quat());

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		burst = 0;
		foreach (rows[i]) begin
			r = rows[i];
			// alternate stretches of back-to-back words and random gaps
			if (i % 100 == 0) burst = $urandom_range(0, 2);
			gap = (burst == 0) ? 0 : $urandom_range(0, 17);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			in_valid <= 1'b1;
			quat_w <= r.w;
			quat_x <= r.x;
			quat_y <= r.y;
			quat_z <= r.z;
			do @(posedge clk); while (!in_ready);
			if (r.typed) angles_due.push_back(r.res);
			else angles_due.push_back(predict_euler(r.w, r.x, r.y, r.z));
		end
		in_valid <= 1'b0;

		wait (angles_due.size() == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (n_errors == 0)
			$display("PASS quaternion_to_euler_angles_top");
		else
			$display("FAIL quaternion_to_euler_angles_top");
		$finish;
	end

	// receiver: random stalls, one long hold to back the pipeline up
	initial begin
		euler_t e;
		int stall, mode;
		mode = 0;
		@(posedge arst_n);
		forever begin
			if (n_seen % 120 == 0) mode = $urandom_range(0, 2);
			stall = (n_seen == 300) ? HOLD_LEN : (mode == 0) ? 0 : $urandom_range(0, 17);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			n_seen++;
			if (angles_due.size() == 0) begin
				$display("unexpected word at cycle %0d", n_cycles);
				n_errors++;
			end else begin
				e = angles_due.pop_front();
				if (roll_angle !== e.roll) report("roll_angle", roll_angle, e.roll);
				if (pitch_angle !== e.pitch) report("pitch_angle", pitch_angle, e.pitch);
				if (yaw_angle !== e.yaw) report("yaw_angle", yaw_angle, e.yaw);
				if (pitch_clamped !== e.clamped)
					report("pitch_clamped", pitch_clamped, e.clamped);
			end
		end
	end

endmodule
